[rtl/core/ctsr_pkg.sv]
package ctsr_pkg;

  localparam int unsigned CntWidth = 30;
  localparam logic [CntWidth-1:0] CntMax = {CntWidth{1'b1}};
  localparam int unsigned OutTagWidth = 32;
  // Ways per set in set-associative mode; a power of two keeps the index split a bit slice.
  localparam int unsigned SetWays = 4;

  typedef enum logic [1:0] {
    OrgDirect = 2'd0,
    OrgSetAssoc = 2'd1,
    OrgFullAssoc = 2'd2,
    OrgSpare = 2'd3
  } org_e;

  typedef enum logic [1:0] {
    CfgOffsetBits = 2'd0,
    CfgLinesLog2 = 2'd1,
    CfgOrganization = 2'd2,
    CfgReplacePolicy = 2'd3
  } cfg_idx_e;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StClear = 6'b000010,
    StScan = 6'b000100,
    StWait = 6'b001000,
    StWrite = 6'b010000,
    StOut = 6'b100000
  } state_e;

  function automatic logic [CntWidth-1:0] sat_inc(input logic [CntWidth-1:0] v);
    sat_inc = (v == CntMax) ? v : v + 1'b1;
  endfunction

endpackage

[rtl/core/ctsr_ram.sv]
module ctsr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/cache_tag_store_with_replacement.sv]
// Channel   Direction  Signals
// cfg       in         cfg_we_i, cfg_index_i, cfg_data_i
// request   in         valid_i, stall_o, address_i
// result    out        valid_o, stall_i, hit_o, evicted_o, victim_tag_o, hit_total_o,
//                      access_total_o
// The ways of the set are read from the line RAM one per cycle (1 for direct-mapped, up to 4
// set-associative, up to the line count fully associative). After acceptance the scan state
// issues the reads, a wait state checks the last read, a write state writes back and an
// output state raises valid_o. The next request is taken the cycle after the result leaves,
// so a transaction ends before the next is taken, and a stalled result holds off the next
// request. After reset a clearing pass zeroes all MAX_LINES valid bits before any request.
module cache_tag_store_with_replacement #(
  parameter int unsigned MAX_LINES = 1024,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [4:0]            cfg_data_i,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic [ADDR_WIDTH-1:0] address_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic                  hit_o,
  output logic                  evicted_o,
  output logic [31:0]           victim_tag_o,
  output logic [29:0]           hit_total_o,
  output logic [29:0]           access_total_o
);

  localparam int unsigned IdxW = $clog2(MAX_LINES);
  localparam int unsigned CntW = ctsr_pkg::CntWidth;
  localparam int unsigned EntW = 1 + ADDR_WIDTH + CntW;
  // Log2 of the largest power of two that fits in MAX_LINES.
  localparam int unsigned MaxL2 = $clog2(MAX_LINES + 1) - 1;
  localparam int unsigned WaysL2 = $clog2(ctsr_pkg::SetWays);

  logic [4:0] offset_q;
  logic [3:0] lines_q;
  logic [1:0] org_q;
  logic       policy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 5'd4;
      lines_q <= 4'd10;
      org_q <= ctsr_pkg::OrgDirect;
      policy_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ctsr_pkg::CfgOffsetBits: offset_q <= cfg_data_i;
        ctsr_pkg::CfgLinesLog2: lines_q <= cfg_data_i[3:0];
        ctsr_pkg::CfgOrganization: org_q <= cfg_data_i[1:0];
        ctsr_pkg::CfgReplacePolicy: policy_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective log2 of lines, ways and sets.
  logic [4:0] ll2, wl2, sl2;
  always_comb begin
    ll2 = (lines_q < 4'd2) ? 5'd2 : {1'b0, lines_q};
    if (ll2 > 5'(MaxL2)) ll2 = (MaxL2 < 2) ? 5'd2 : 5'(MaxL2);
    case (org_q)
      ctsr_pkg::OrgDirect: wl2 = 5'd0;
      ctsr_pkg::OrgSetAssoc: wl2 = (5'(WaysL2) < ll2) ? 5'(WaysL2) : ll2;
      default: wl2 = ll2;
    endcase
    sl2 = ll2 - wl2;
  end

  ctsr_pkg::state_e state_q, state_d;
  logic [IdxW:0]       clr_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic [IdxW-1:0]     base_q;
  logic [IdxW:0]       rd_q;      // ways issued
  logic [IdxW:0]       chk_q;     // ways checked
  logic [IdxW:0]       nways_q;
  logic                found_q, inv_q;
  logic [IdxW-1:0]     hit_w_q, inv_w_q, min_w_q;
  logic [CntW-1:0]     min_s_q;
  logic [ADDR_WIDTH-1:0] min_t_q;
  logic [CntW-1:0]     acc_q, hits_q;
  logic                ov_q, oe_q;
  logic [31:0]         ovt_q;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [EntW-1:0] wdata, rdata;

  ctsr_ram #(.Width(EntW), .Depth(MAX_LINES)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic                  r_v;
  logic [ADDR_WIDTH-1:0] r_t;
  logic [CntW-1:0]       r_s;
  assign {r_v, r_t, r_s} = rdata;

  logic [ADDR_WIDTH-1:0] blk;
  logic [ADDR_WIDTH-1:0] smask;
  assign blk = address_i >> offset_q;
  assign smask = ~({ADDR_WIDTH{1'b1}} << sl2);

  logic take;
  assign stall_o = !(state_q == ctsr_pkg::StIdle) || valid_o;
  assign take = valid_i && !stall_o;

  logic chk_now;
  assign chk_now = (state_q == ctsr_pkg::StScan && rd_q != '0) ||
                   state_q == ctsr_pkg::StWait;

  always_comb begin
    state_d = state_q;
    we = 1'b0;
    waddr = base_q + rd_q[IdxW-1:0];
    wdata = '0;
    raddr = base_q + rd_q[IdxW-1:0];
    unique case (state_q)
      ctsr_pkg::StClear: begin
        we = 1'b1;
        waddr = clr_q[IdxW-1:0];
        if (clr_q == (IdxW+1)'(MAX_LINES - 1)) state_d = ctsr_pkg::StIdle;
      end
      ctsr_pkg::StIdle: if (take) state_d = ctsr_pkg::StScan;
      ctsr_pkg::StScan: if (rd_q + 1'b1 == nways_q) state_d = ctsr_pkg::StWait;
      ctsr_pkg::StWait: state_d = ctsr_pkg::StWrite;
      ctsr_pkg::StWrite: begin
        state_d = ctsr_pkg::StOut;
        wdata = {1'b1, tag_q, acc_q};
        if (found_q) begin
          we = policy_q;
          waddr = base_q + hit_w_q;
          wdata = {1'b1, tag_q, acc_q};
        end else if (inv_q) begin
          we = 1'b1;
          waddr = base_q + inv_w_q;
        end else begin
          we = 1'b1;
          waddr = base_q + min_w_q;
        end
      end
      ctsr_pkg::StOut: state_d = ctsr_pkg::StIdle;
      default: state_d = ctsr_pkg::StIdle;
    endcase
  end

  logic [IdxW-1:0] chk_w;
  assign chk_w = chk_q[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ctsr_pkg::StClear;
      clr_q <= '0;
      acc_q <= '0;
      hits_q <= '0;
      valid_o <= 1'b0;
      rd_q <= '0;
      chk_q <= '0;
      found_q <= 1'b0;
      inv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ctsr_pkg::StClear) clr_q <= clr_q + 1'b1;
      if (valid_o && !stall_i) valid_o <= 1'b0;
      if (take) begin
        acc_q <= ctsr_pkg::sat_inc(acc_q);
        tag_q <= (blk >> sl2);
        base_q <= IdxW'((blk & smask) << wl2);
        nways_q <= (IdxW+1)'(1) << wl2;
        rd_q <= '0;
        chk_q <= '0;
        found_q <= 1'b0;
        inv_q <= 1'b0;
      end
      if (state_q == ctsr_pkg::StScan) rd_q <= rd_q + 1'b1;
      if (chk_now) begin
        chk_q <= chk_q + 1'b1;
        if (!found_q && r_v && r_t == tag_q) begin
          found_q <= 1'b1;
          hit_w_q <= chk_w;
        end
        if (!inv_q && !r_v) begin
          inv_q <= 1'b1;
          inv_w_q <= chk_w;
        end
        if (chk_q == '0 || r_s < min_s_q) begin
          min_s_q <= r_s;
          min_w_q <= chk_w;
          min_t_q <= r_t;
        end
      end
      if (state_q == ctsr_pkg::StWrite) begin
        if (found_q) hits_q <= ctsr_pkg::sat_inc(hits_q);
        ov_q <= found_q;
        oe_q <= !found_q && !inv_q;
        ovt_q <= (!found_q && !inv_q) ? 32'(min_t_q) : 32'd0;
      end
      if (state_q == ctsr_pkg::StOut) valid_o <= 1'b1;
    end
  end

  assign hit_o = ov_q;
  assign evicted_o = oe_q;
  assign victim_tag_o = ovt_q;
  assign hit_total_o = hits_q;
  assign access_total_o = acc_q;

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ctsr_pkg::StIdle) |-> !take) else $error("take while busy");
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(hit_o && evicted_o)) else $error("hit and evict");
  a_no_write_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !we) else $error("write while result pending");

endmodule
